FILE: rtl/ptg_pkg.sv
package ptg_pkg;

   // Phase format: unsigned fixed point, integer ticks above FRAC_BITS fraction bits.
   localparam int FRAC_BITS = 16;
   localparam int INT_BITS  = 16;
   localparam int PHASE_W   = INT_BITS + FRAC_BITS;
   localparam int STEP_W    = 24;
   localparam int SUM_W     = PHASE_W + 1;
   localparam int QUOT_BITS = SUM_W - FRAC_BITS;
   localparam int CNT_W     = $clog2(QUOT_BITS);
   localparam int HALF_W    = INT_BITS + 1;
   localparam int LEVEL_W   = 15;
   localparam int SAMPLE_W  = 16;

   localparam logic [15:0] PORT_TIMER_DATA = 16'h0042;
   localparam logic [15:0] PORT_TIMER_CMD  = 16'h0043;
   localparam logic [15:0] PORT_SYS_CTRL   = 16'h0061;

   localparam logic [1:0] CSR_PHASE_STEP = 2'd0;
   localparam logic [1:0] CSR_MIX_ENABLE = 2'd1;
   localparam logic [1:0] CSR_TONE_LEVEL = 2'd2;

   localparam logic [STEP_W-1:0]  PHASE_STEP_RESET = STEP_W'(1773160);
   localparam logic [LEVEL_W-1:0] TONE_LEVEL_RESET = LEVEL_W'(4000);
   localparam logic [INT_BITS-1:0] RELOAD_RESET    = '1;
   localparam logic [HALF_W-1:0]  HALF_RESET       = HALF_W'(65535);

   localparam logic [1:0] CHANNEL_TWO  = 2'd2;
   localparam logic [1:0] ACCESS_LATCH = 2'd0;
   localparam logic [1:0] ACCESS_LOW   = 2'd1;
   localparam logic [1:0] ACCESS_HIGH  = 2'd2;
   localparam logic [1:0] ACCESS_BOTH  = 2'd3;

   localparam logic [2:0] MODE_RATE   = 3'd2;
   localparam logic [2:0] MODE_SQUARE = 3'd3;

   localparam logic [1:0] SPEAKER_DATA_ONLY = 2'b10;
   localparam logic [1:0] SPEAKER_ON        = 2'b11;

   localparam logic signed [SAMPLE_W:0] SAMPLE_MAX = 17'sd32767;
   localparam logic signed [SAMPLE_W:0] SAMPLE_MIN = -17'sd32768;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_LEVEL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic port_write;
      logic sample_start;
      logic div_step;
      logic div_last;
      logic level_load;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic wave;
      logic phase_in_range;
   } dp_status_type;

endpackage

FILE: rtl/ptg_ctrl.sv
module ptg_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_mode,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  ptg_pkg::dp_status_type  sts,
   output ptg_pkg::ctrl_cmd_type   cmd,
   output ptg_pkg::state_type      state
);

   ptg_pkg::state_type             state_ff;
   ptg_pkg::state_type             state_in;
   logic [ptg_pkg::CNT_W-1:0]      count_ff;
   logic [ptg_pkg::CNT_W-1:0]      count_in;
   logic                           valid_ff;
   logic                           valid_in;
   logic                           slot_free;

   assign slot_free  = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign state      = state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptg_pkg::ST_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      cmd        = '0;
      req_tready = 1'b0;
      valid_in   = valid_ff && !rsp_tready;
      case (state_ff)
         ptg_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            count_in   = '0;
            if (req_tvalid) begin
               if (!req_mode) begin
                  cmd.port_write = 1'b1;
               end else begin
                  cmd.sample_start = 1'b1;
                  state_in = sts.wave ? ptg_pkg::ST_DIVIDE : ptg_pkg::ST_LEVEL;
               end
            end
         end
         ptg_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
            if (count_ff == ptg_pkg::CNT_W'(ptg_pkg::QUOT_BITS - 1)) begin
               cmd.div_last = 1'b1;
               state_in     = ptg_pkg::ST_LEVEL;
            end
         end
         ptg_pkg::ST_LEVEL: begin
            cmd.level_load = 1'b1;
            state_in       = ptg_pkg::ST_DONE;
         end
         ptg_pkg::ST_DONE: begin
            // The single output register may still hold the previous sample.
            if (slot_free) begin
               cmd.out_load = 1'b1;
               valid_in     = 1'b1;
               state_in     = ptg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptg_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/ptg_datapath.sv
module ptg_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  ptg_pkg::ctrl_cmd_type               cmd,
   output ptg_pkg::dp_status_type              sts,
   input  logic [15:0]                         port_address,
   input  logic [7:0]                          write_data,
   input  logic signed [ptg_pkg::SAMPLE_W-1:0] mix_left,
   input  logic signed [ptg_pkg::SAMPLE_W-1:0] mix_right,
   input  logic                                csr_write,
   input  logic [1:0]                          csr_index,
   input  logic [ptg_pkg::STEP_W-1:0]          csr_data,
   output logic signed [ptg_pkg::SAMPLE_W-1:0] left_sample,
   output logic signed [ptg_pkg::SAMPLE_W-1:0] right_sample
);

   // Configuration registers
   logic [ptg_pkg::STEP_W-1:0]    step_ff;
   logic                          mix_en_ff;
   logic [ptg_pkg::LEVEL_W-1:0]   tone_ff;

   // Timer channel state
   logic [1:0]                    gd_ff, gd_in;
   logic [ptg_pkg::INT_BITS-1:0]  reload_ff, reload_in;
   logic [2:0]                    cmode_ff, cmode_in;
   logic [1:0]                    access_ff, access_in;
   logic                          hbn_ff, hbn_in;
   logic [ptg_pkg::INT_BITS-1:0]  period_ff, period_in;
   logic [ptg_pkg::HALF_W-1:0]    half_ff, half_in;
   logic [ptg_pkg::PHASE_W-1:0]   phase_ff, phase_in;

   // Remainder unit and sample path
   logic [ptg_pkg::QUOT_BITS-1:0] div_ff, div_in;
   logic [ptg_pkg::FRAC_BITS-1:0] frac_ff, frac_in;
   logic [ptg_pkg::INT_BITS-1:0]  rem_ff, rem_in;
   logic signed [ptg_pkg::SAMPLE_W-1:0] mixl_ff, mixr_ff;
   logic signed [ptg_pkg::SAMPLE_W-1:0] level_ff, level_in;
   logic signed [ptg_pkg::SAMPLE_W-1:0] left_ff, left_in, right_ff, right_in;

   logic                          reload_event;
   logic [2:0]                    fold_mode;
   logic [ptg_pkg::SUM_W-1:0]     sum;
   logic [ptg_pkg::INT_BITS:0]    trial;
   logic [ptg_pkg::INT_BITS:0]    trial_diff;
   logic [ptg_pkg::INT_BITS-1:0]  rem_next;
   logic                          low_half;
   logic signed [ptg_pkg::SAMPLE_W-1:0] tone_pos;
   logic signed [ptg_pkg::SAMPLE_W:0]   sum_l, sum_r;

   assign sts.wave           = (gd_ff == ptg_pkg::SPEAKER_ON) && (reload_ff[15:1] != '0);
   assign sts.phase_in_range = phase_ff[ptg_pkg::PHASE_W-1:ptg_pkg::FRAC_BITS] < period_ff;

   assign left_sample  = left_ff;
   assign right_sample = right_ff;

   assign sum = {1'b0, phase_ff} + ptg_pkg::SUM_W'(step_ff);

   // One restoring step of the integer phase modulo the period.
   assign trial      = {rem_ff, div_ff[ptg_pkg::QUOT_BITS-1]};
   assign trial_diff = trial - {1'b0, period_ff};
   assign rem_next   = (trial >= {1'b0, period_ff}) ? trial_diff[ptg_pkg::INT_BITS-1:0]
                                                   : trial[ptg_pkg::INT_BITS-1:0];

   assign low_half = {phase_ff, 1'b0} < {half_ff, {ptg_pkg::FRAC_BITS{1'b0}}};
   assign tone_pos = $signed({1'b0, tone_ff});

   assign sum_l = $signed({mixl_ff[ptg_pkg::SAMPLE_W-1], mixl_ff})
                + $signed({level_ff[ptg_pkg::SAMPLE_W-1], level_ff});
   assign sum_r = $signed({mixr_ff[ptg_pkg::SAMPLE_W-1], mixr_ff})
                + $signed({level_ff[ptg_pkg::SAMPLE_W-1], level_ff});

   assign fold_mode = (write_data[3] && write_data[2]) ? {1'b0, write_data[2:1]}
                                                       : write_data[3:1];

   always_comb begin
      gd_in        = gd_ff;
      reload_in    = reload_ff;
      cmode_in     = cmode_ff;
      access_in    = access_ff;
      hbn_in       = hbn_ff;
      period_in    = period_ff;
      half_in      = half_ff;
      phase_in     = phase_ff;
      reload_event = 1'b0;

      if (cmd.port_write) begin
         if (port_address == ptg_pkg::PORT_TIMER_CMD) begin
            if (write_data[7:6] == ptg_pkg::CHANNEL_TWO &&
                write_data[5:4] != ptg_pkg::ACCESS_LATCH) begin
               access_in = write_data[5:4];
               cmode_in  = fold_mode;
               hbn_in    = 1'b0;
            end
         end else if (port_address == ptg_pkg::PORT_TIMER_DATA) begin
            case (access_ff)
               ptg_pkg::ACCESS_LOW: begin
                  reload_in    = {reload_ff[15:8], write_data};
                  reload_event = 1'b1;
               end
               ptg_pkg::ACCESS_HIGH: begin
                  reload_in    = {write_data, reload_ff[7:0]};
                  reload_event = 1'b1;
               end
               ptg_pkg::ACCESS_BOTH: begin
                  if (!hbn_ff) begin
                     reload_in = {reload_ff[15:8], write_data};
                     hbn_in    = 1'b1;
                  end else begin
                     reload_in    = {write_data, reload_ff[7:0]};
                     hbn_in       = 1'b0;
                     reload_event = 1'b1;
                     phase_in     = '0;
                  end
               end
               default: begin
               end
            endcase
         end else if (port_address == ptg_pkg::PORT_SYS_CTRL) begin
            gd_in = write_data[1:0];
         end
      end

      // A zero count keeps the old timing.
      if (reload_event && reload_in != '0) begin
         period_in = reload_in;
         if (cmode_ff == ptg_pkg::MODE_RATE) begin
            half_in = ptg_pkg::HALF_W'(2);
         end else if (cmode_ff == ptg_pkg::MODE_SQUARE) begin
            half_in = {1'b0, reload_in};
         end else begin
            half_in = {reload_in, 1'b0};
         end
      end

      if (cmd.div_last) begin
         phase_in = {rem_next, frac_ff};
      end
   end

   always_comb begin
      div_in  = div_ff;
      frac_in = frac_ff;
      rem_in  = rem_ff;
      if (cmd.sample_start) begin
         div_in  = sum[ptg_pkg::SUM_W-1:ptg_pkg::FRAC_BITS];
         frac_in = sum[ptg_pkg::FRAC_BITS-1:0];
         rem_in  = '0;
      end else if (cmd.div_step) begin
         div_in = {div_ff[ptg_pkg::QUOT_BITS-2:0], 1'b0};
         rem_in = rem_next;
      end
   end

   always_comb begin
      if (gd_ff == ptg_pkg::SPEAKER_DATA_ONLY) begin
         level_in = tone_pos;
      end else if (sts.wave) begin
         if (cmode_ff == ptg_pkg::MODE_SQUARE) begin
            level_in = low_half ? tone_pos : -tone_pos;
         end else begin
            level_in = low_half ? -tone_pos : tone_pos;
         end
      end else begin
         level_in = '0;
      end
   end

   always_comb begin
      if (!mix_en_ff) begin
         left_in  = level_ff;
         right_in = level_ff;
      end else begin
         if (sum_l > ptg_pkg::SAMPLE_MAX) begin
            left_in = ptg_pkg::SAMPLE_MAX[ptg_pkg::SAMPLE_W-1:0];
         end else if (sum_l < ptg_pkg::SAMPLE_MIN) begin
            left_in = ptg_pkg::SAMPLE_MIN[ptg_pkg::SAMPLE_W-1:0];
         end else begin
            left_in = sum_l[ptg_pkg::SAMPLE_W-1:0];
         end
         if (sum_r > ptg_pkg::SAMPLE_MAX) begin
            right_in = ptg_pkg::SAMPLE_MAX[ptg_pkg::SAMPLE_W-1:0];
         end else if (sum_r < ptg_pkg::SAMPLE_MIN) begin
            right_in = ptg_pkg::SAMPLE_MIN[ptg_pkg::SAMPLE_W-1:0];
         end else begin
            right_in = sum_r[ptg_pkg::SAMPLE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= ptg_pkg::PHASE_STEP_RESET;
         mix_en_ff <= 1'b1;
         tone_ff   <= ptg_pkg::TONE_LEVEL_RESET;
         gd_ff     <= '0;
         reload_ff <= ptg_pkg::RELOAD_RESET;
         cmode_ff  <= ptg_pkg::MODE_SQUARE;
         access_ff <= ptg_pkg::ACCESS_BOTH;
         hbn_ff    <= 1'b0;
         period_ff <= ptg_pkg::RELOAD_RESET;
         half_ff   <= ptg_pkg::HALF_RESET;
         phase_ff  <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               ptg_pkg::CSR_PHASE_STEP: step_ff   <= csr_data;
               ptg_pkg::CSR_MIX_ENABLE: mix_en_ff <= csr_data[0];
               ptg_pkg::CSR_TONE_LEVEL: tone_ff   <= csr_data[ptg_pkg::LEVEL_W-1:0];
               default: begin
               end
            endcase
         end
         gd_ff     <= gd_in;
         reload_ff <= reload_in;
         cmode_ff  <= cmode_in;
         access_ff <= access_in;
         hbn_ff    <= hbn_in;
         period_ff <= period_in;
         half_ff   <= half_in;
         phase_ff  <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      frac_ff <= frac_in;
      rem_ff  <= rem_in;
      if (cmd.sample_start) begin
         mixl_ff <= mix_left;
         mixr_ff <= mix_right;
      end
      if (cmd.level_load) begin
         level_ff <= level_in;
      end
      if (cmd.out_load) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

endmodule

FILE: rtl/pc_speaker_tone_generator.sv
// Channel  Direction  Handshake                 Payload
// req      in         req_tvalid / req_tready   tuser: mode; tdata: address, byte, stereo pair
// rsp      out        rsp_tvalid / rsp_tready   tdata: left and right sample
// csr      in         csr_valid / csr_ready     csr_index, csr_data
//
// A port write is applied at acceptance and gives no result.
// A sample that plays the timer wave runs the 17-step restoring remainder of the integer phase
// against the period, then loads its level and, once the output register is free, registers it.
// A fixed-level or silent sample skips the remainder; each sample ends with a return to idle.
// Reset is synchronous and restores the timer and configuration defaults.
// The result sits in one output register; a new item is taken while it waits,
// and a sample that finishes before it is taken holds in the sequencer.
module pc_speaker_tone_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,   // [0] mode
   input  logic [55:0] req_tdata,   // [15:0] port_address, [23:16] write_data,
                                    // [39:24] mix_left, [55:40] mix_right
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] left_sample, [31:16] right_sample
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);

   ptg_pkg::ctrl_cmd_type                 cmd;
   ptg_pkg::dp_status_type                sts;
   ptg_pkg::state_type                    state;
   logic signed [ptg_pkg::SAMPLE_W-1:0]   left_sample;
   logic signed [ptg_pkg::SAMPLE_W-1:0]   right_sample;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {right_sample, left_sample};

   ptg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser[0]),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd),
      .state      (state)
   );

   ptg_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .port_address (req_tdata[15:0]),
      .write_data   (req_tdata[23:16]),
      .mix_left     ($signed(req_tdata[39:24])),
      .mix_right    ($signed(req_tdata[55:40])),
      .csr_write    (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .left_sample  (left_sample),
      .right_sample (right_sample)
   );

   // The integer phase must be reduced below the period when the divide ends.
   a_phase_reduced: assert property (@(posedge clock) disable iff (reset)
      (state == ptg_pkg::ST_LEVEL && sts.wave) |-> sts.phase_in_range)
      else $error("phase not reduced below period");

   // A port write never produces a result.
   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tuser[0] && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("port write produced a result");

   // A sample without the timer wave skips the remainder unit.
   a_fixed_skip: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0] && !sts.wave) |=> state == ptg_pkg::ST_LEVEL)
      else $error("fixed-level sample entered the divide");

   // New items are taken only while the sequencer is idle.
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state != ptg_pkg::ST_IDLE) |-> !req_tready)
      else $error("item accepted while busy");

endmodule

FILE: test/pc_speaker_tone_generator_tb.sv
typedef enum logic {
   REQ_PORT_WRITE = 1'b0,
   REQ_SAMPLE     = 1'b1
} request_kind_type;

// Tracks the timer channel and speaker state that the accepted transactions build up, and
// keeps the stereo samples that the block still owes.
class tone_scoreboard;
   logic [23:0] step_q16;
   logic        mixing;
   logic [14:0] amplitude;

   logic [1:0]  speaker_bits;
   logic [15:0] reload;
   logic [2:0]  timer_mode;
   logic [1:0]  rw_mode;
   logic        expect_msb;
   logic [15:0] period;
   logic [16:0] half_ticks;
   logic [47:0] phase_acc;

   logic [31:0] expected_samples[$];
   int          error_count;

   function new();
      step_q16     = ptg_pkg::PHASE_STEP_RESET;
      mixing       = 1'b1;
      amplitude    = ptg_pkg::TONE_LEVEL_RESET;
      speaker_bits = 2'b00;
      reload       = ptg_pkg::RELOAD_RESET;
      timer_mode   = ptg_pkg::MODE_SQUARE;
      rw_mode      = ptg_pkg::ACCESS_BOTH;
      expect_msb   = 1'b0;
      period       = ptg_pkg::RELOAD_RESET;
      half_ticks   = ptg_pkg::HALF_RESET;
      phase_acc    = '0;
      error_count  = 0;
   endfunction

   function int pending();
      return expected_samples.size();
   endfunction

   function void set_register(logic [1:0] index, logic [23:0] value);
      case (index)
         ptg_pkg::CSR_PHASE_STEP: step_q16 = value;
         ptg_pkg::CSR_MIX_ENABLE: mixing = value[0];
         ptg_pkg::CSR_TONE_LEVEL: amplitude = value[14:0];
         default: ;
      endcase
   endfunction

   // A count of zero keeps the old period; the half period is kept in units of half a tick.
   function void retime();
      if (reload != '0) begin
         period = reload;
         if (timer_mode == ptg_pkg::MODE_RATE) begin
            half_ticks = 17'd2;
         end else if (timer_mode == ptg_pkg::MODE_SQUARE) begin
            half_ticks = {1'b0, reload};
         end else begin
            half_ticks = {reload, 1'b0};
         end
      end
   endfunction

   function void apply_port_write(logic [15:0] port, logic [7:0] value);
      logic [2:0] m;
      if (port == ptg_pkg::PORT_TIMER_CMD) begin
         if (value[7:6] == ptg_pkg::CHANNEL_TWO && value[5:4] != ptg_pkg::ACCESS_LATCH) begin
            m = value[3:1];
            // Modes six and seven are aliases of two and three.
            if (m[2] && m[1]) m[2] = 1'b0;
            rw_mode    = value[5:4];
            timer_mode = m;
            expect_msb = 1'b0;
         end
      end else if (port == ptg_pkg::PORT_TIMER_DATA) begin
         case (rw_mode)
            ptg_pkg::ACCESS_LOW: begin
               reload[7:0] = value;
               retime();
            end
            ptg_pkg::ACCESS_HIGH: begin
               reload[15:8] = value;
               retime();
            end
            ptg_pkg::ACCESS_BOTH: begin
               if (!expect_msb) begin
                  reload[7:0] = value;
                  expect_msb  = 1'b1;
               end else begin
                  reload[15:8] = value;
                  expect_msb   = 1'b0;
                  retime();
                  phase_acc = '0;
               end
            end
            default: ;
         endcase
      end else if (port == ptg_pkg::PORT_SYS_CTRL) begin
         speaker_bits = value[1:0];
      end
   endfunction

   function int tone_sample_level();
      int          lvl = int'(amplitude);
      logic [47:0] span;
      logic        first_half;
      if (speaker_bits == ptg_pkg::SPEAKER_DATA_ONLY) return lvl;
      if (speaker_bits != ptg_pkg::SPEAKER_ON || reload < 16'd2) return 0;
      span      = 48'(period) << ptg_pkg::FRAC_BITS;
      phase_acc = (phase_acc + 48'(step_q16)) % span;
      first_half = (phase_acc << 1) < (48'(half_ticks) << ptg_pkg::FRAC_BITS);
      if (timer_mode == ptg_pkg::MODE_SQUARE) return first_half ? lvl : -lvl;
      return first_half ? -lvl : lvl;
   endfunction

   function logic [15:0] mix_channel(logic [15:0] existing, int lvl);
      int sum = int'($signed(existing)) + lvl;
      if (sum > ptg_pkg::SAMPLE_MAX) sum = ptg_pkg::SAMPLE_MAX;
      if (sum < ptg_pkg::SAMPLE_MIN) sum = ptg_pkg::SAMPLE_MIN;
      return sum[15:0];
   endfunction

   function void note_request(request_kind_type kind, logic [15:0] port, logic [7:0] value,
                              logic [15:0] left, logic [15:0] right);
      int lvl;
      if (kind == REQ_PORT_WRITE) begin
         apply_port_write(port, value);
      end else begin
         lvl = tone_sample_level();
         if (mixing) begin
            expected_samples.push_back({mix_channel(right, lvl), mix_channel(left, lvl)});
         end else begin
            expected_samples.push_back({lvl[15:0], lvl[15:0]});
         end
      end
   endfunction

   function void flag(string field, longint unsigned stamp, int want, int got);
      error_count++;
      $display("%0d ns: %s mismatch: expected %0d, actual %0d", stamp, field, want, got);
   endfunction

   function void check_sample(logic [31:0] actual, longint unsigned stamp);
      logic [31:0] want;
      if (expected_samples.size() == 0) begin
         error_count++;
         $display("%0d ns: unexpected sample: expected none, actual %h", stamp, actual);
         return;
      end
      want = expected_samples.pop_front();
      if (actual[15:0] !== want[15:0]) begin
         flag("left_sample", stamp, $signed(want[15:0]), $signed(actual[15:0]));
      end
      if (actual[31:16] !== want[31:16]) begin
         flag("right_sample", stamp, $signed(want[31:16]), $signed(actual[31:16]));
      end
   endfunction
endclass

module pc_speaker_tone_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 310;
   localparam int SETTLE_CYCLES   = 30;
   localparam int WATCHDOG_LIMIT  = 2000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [0:0]  req_tuser  = REQ_PORT_WRITE;
   logic [55:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = ptg_pkg::CSR_PHASE_STEP;
   logic [23:0] csr_data   = '0;

   tone_scoreboard board = new();
   int items_sent   = 0;
   bit idle_on      = 1'b1;
   int stall_left   = 0;
   int quiet_cycles = 0;

   pc_speaker_tone_generator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Result side: check each transaction and throttle tready in random bursts.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_sample(rsp_tdata, $time);
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 11);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0d ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Leaves tvalid high after acceptance so that back-to-back items keep tvalid asserted between them.
   task automatic send_request(input request_kind_type kind, input logic [15:0] port,
                               input logic [7:0] value, input logic [15:0] left,
                               input logic [15:0] right);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {right, left, value, port};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(kind, port, value, left, right);
      if (kind == REQ_SAMPLE || port == ptg_pkg::PORT_TIMER_CMD ||
          port == ptg_pkg::PORT_TIMER_DATA || port == ptg_pkg::PORT_SYS_CTRL) begin
         items_sent++;
      end
   endtask

   function automatic logic [15:0] random_mix();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic write_port(input logic [15:0] port, input logic [7:0] value);
      send_request(REQ_PORT_WRITE, port, value, 16'($urandom), 16'($urandom));
   endtask

   task automatic request_sample(input logic [15:0] left, input logic [15:0] right);
      send_request(REQ_SAMPLE, 16'($urandom), 8'($urandom), left, right);
   endtask

   task automatic sample_random();
      request_sample(random_mix(), random_mix());
   endtask

   // Waits for every owed sample, then lets any trailing work in the block finish.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_register(index, value);
   endtask

   task automatic configure(input logic [23:0] step, input logic [23:0] mix_word,
                            input logic [23:0] level_word);
      write_csr(ptg_pkg::CSR_PHASE_STEP, step);
      write_csr(ptg_pkg::CSR_MIX_ENABLE, mix_word);
      write_csr(ptg_pkg::CSR_TONE_LEVEL, level_word);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // A complete reprogramming of channel 2 followed by a burst of samples.
   task automatic program_timer();
      logic [1:0]  rw;
      logic [2:0]  m;
      logic [15:0] count;
      rw = 2'($urandom_range(ptg_pkg::ACCESS_LOW, ptg_pkg::ACCESS_BOTH));
      m  = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
         0: count = 16'h0000;
         1: count = 16'h0001;
         2: count = 16'hFFFF;
         3: count = 16'($urandom);
         default: count = 16'($urandom_range(2, 400));
      endcase
      write_port(ptg_pkg::PORT_TIMER_CMD, {ptg_pkg::CHANNEL_TWO, rw, m, 1'($urandom)});
      if (rw != ptg_pkg::ACCESS_HIGH) write_port(ptg_pkg::PORT_TIMER_DATA, count[7:0]);
      if (rw != ptg_pkg::ACCESS_LOW) write_port(ptg_pkg::PORT_TIMER_DATA, count[15:8]);
      if ($urandom_range(0, 3) == 0) begin
         write_port(ptg_pkg::PORT_SYS_CTRL, 8'($urandom));
      end else begin
         write_port(ptg_pkg::PORT_SYS_CTRL, {6'($urandom), ptg_pkg::SPEAKER_ON});
      end
      repeat ($urandom_range(4, 20)) sample_random();
   endtask

   task automatic port_noise();
      repeat ($urandom_range(1, 3)) begin
         case ($urandom_range(0, 3))
            0: write_port(16'($urandom), 8'($urandom));
            1: write_port(ptg_pkg::PORT_TIMER_CMD, 8'($urandom));
            2: write_port(ptg_pkg::PORT_TIMER_DATA, 8'($urandom));
            default: write_port(ptg_pkg::PORT_SYS_CTRL, 8'($urandom));
         endcase
      end
   endtask

   initial begin
      int phase_goal;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with the configuration left at its reset values.
      request_sample(16'h7FFF, 16'h8000);
      write_port(ptg_pkg::PORT_SYS_CTRL, 8'hFE);
      request_sample(16'h7FFF, 16'h8000);
      write_port(ptg_pkg::PORT_SYS_CTRL, 8'h03);
      request_sample(16'h0000, 16'h0000);
      write_port(ptg_pkg::PORT_TIMER_CMD, 8'h36);
      write_port(ptg_pkg::PORT_TIMER_CMD, 8'h80);
      // Channel 2, both bytes, mode seven with the BCD bit set.
      write_port(ptg_pkg::PORT_TIMER_CMD, 8'hBF);
      write_port(ptg_pkg::PORT_TIMER_DATA, 8'h01);
      write_port(ptg_pkg::PORT_TIMER_DATA, 8'h00);
      request_sample(16'h8000, 16'h7FFF);
      write_port(ptg_pkg::PORT_TIMER_CMD, 8'hB4);
      // A zero count keeps the period but still restarts the phase.
      write_port(ptg_pkg::PORT_TIMER_DATA, 8'h00);
      write_port(ptg_pkg::PORT_TIMER_DATA, 8'h00);
      write_port(ptg_pkg::PORT_TIMER_DATA, 8'h10);
      write_port(ptg_pkg::PORT_TIMER_DATA, 8'h00);
      request_sample(16'h1234, 16'hFEDC);
      request_sample(16'h0000, 16'hFFFF);
      // Low byte only, mode five: the next sample still uses the old half period.
      write_port(ptg_pkg::PORT_TIMER_CMD, 8'h9A);
      request_sample(16'h0001, 16'h8001);
      write_port(ptg_pkg::PORT_TIMER_DATA, 8'h20);
      request_sample(16'h7FFE, 16'h8000);
      write_port(ptg_pkg::PORT_TIMER_CMD, 8'hA6);
      write_port(ptg_pkg::PORT_TIMER_DATA, 8'h01);
      request_sample(16'h0000, 16'h0000);
      write_port(16'hFFFF, 8'hFF);
      write_port(ptg_pkg::PORT_SYS_CTRL, 8'h01);
      request_sample(16'h7FFF, 16'h8000);

      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         case (p)
            0: configure(24'($urandom_range(1, 24'hFFFFFF)), {23'($urandom), 1'b1},
                         24'($urandom));
            1: configure(24'hFFFFFF, 24'h000000, 24'h007FFF);
            2: configure(24'h000001, 24'hFFFFFF, 24'hFF8000);
            3: configure(24'($urandom_range(1, 24'hFFFFFF)), {23'($urandom), 1'b0},
                         24'($urandom));
            4: configure(24'($urandom_range(24'h010000, 24'h200000)), 24'h000001,
                         24'h007FFF);
            default: configure(ptg_pkg::PHASE_STEP_RESET, 24'h000001, 24'($urandom));
         endcase
         idle_on    = (p != 2 && p != PHASES - 1);
         phase_goal = items_sent + ITEMS_PER_PHASE;
         while (items_sent < phase_goal) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: program_timer();
               6, 7: repeat ($urandom_range(3, 10)) sample_random();
               default: port_noise();
            endcase
            if ($urandom_range(0, 49) == 0) drain_results();
         end
      end

      drain_results();
      if (board.error_count == 0 && board.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

FILE: filelist.f
rtl/ptg_pkg.sv
rtl/ptg_ctrl.sv
rtl/ptg_datapath.sv
rtl/pc_speaker_tone_generator.sv
test/pc_speaker_tone_generator_tb.sv
